### rtl/core/pta_pkg.sv
// ----------------------------------------------------------------------------
// pta_pkg
// Types and constants shared by the pedal torque arbiter.
// ----------------------------------------------------------------------------
package pta_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_T,
      ST_MUL_L,
      ST_DIV_L,
      ST_MUL_R,
      ST_DIV_R,
      ST_DONE
   } state_type;

   localparam int MUL_W  = 24;
   localparam int PROD_W = 2 * MUL_W;
   localparam int REQ_W  = 40;
   localparam int RSP_W  = 48;

   localparam logic CSR_BRAKE_CUTOFF  = 1'b0;
   localparam logic CSR_SCALE_PERCENT = 1'b1;

   localparam logic [7:0]  CUTOFF_RESET         = 8'd50;
   localparam logic [6:0]  PERCENT_RESET        = 7'd100;
   localparam logic [6:0]  PERCENT_FULL         = 7'd100;
   localparam logic [7:0]  AGREE_LIMIT          = 8'd25;
   localparam logic [7:0]  RELEASE_LIMIT        = 8'd13;
   localparam logic [7:0]  PUSH_LIMIT           = 8'd64;
   localparam logic [7:0]  BRAKE_CONFLICT_LIMIT = 8'd50;
   localparam logic [7:0]  STEER_CENTER         = 8'd128;
   localparam logic [10:0] SCALE_UNIT           = 11'd1000;
   localparam logic [10:0] SCALE_MIN            = 11'd250;
   localparam logic [10:0] SCALE_MAX            = 11'd1750;
   localparam logic [15:0] WORD_MAX             = 16'hFFFF;

   // ceil(2^19 * 32 / 25): exact for products of throttle and percent
   localparam logic [MUL_W-1:0] RECIP_25  = 24'd671089;
   // ceil(2^30 / 125): exact for values below 2^23
   localparam logic [MUL_W-1:0] RECIP_125 = 24'd8589935;

endpackage

### rtl/core/pedal_torque_arbiter.sv
// ----------------------------------------------------------------------------
// pedal_torque_arbiter
// Throttle plausibility, brake light, conflict latch and torque vectoring
// for one pedal frame, on one shared 24x24 multiplier.
// ----------------------------------------------------------------------------
//  channel  direction  ports                  beat contents
//  req      in         req_tvalid/tready/data one pedal frame
//  rsp      out        rsp_tvalid/tready/data one torque command
//  csr      in         csr_we/index/wdata     register write, no wait
//
//  rsp_tvalid rises as req_tready returns, so a new frame is taken only once
//  the last result has been loaded into the output register: a sequencer
//  steps the single multiplier through six products (percent, /25, left
//  scale, /1000, right scale, /1000), one per cycle, then a done state loads it
//  req_tready is high only while the sequencer is idle
//  the result waits in an output register; a stalled rsp holds the sequencer
//  reset is synchronous, clears the latch and loads register defaults
// ----------------------------------------------------------------------------
module pedal_torque_arbiter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // throttle_a, throttle_b, brake_level, steering_pos, drive_enabled, zeros
   input  logic [pta_pkg::REQ_W-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // brake_light, throttle_used, sensors_agree, conflict_flag, torque_sent,
   // left_torque, right_torque_word, zeros
   output logic [pta_pkg::RSP_W-1:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int MW = pta_pkg::MUL_W;
   localparam int PW = pta_pkg::PROD_W;

   pta_pkg::state_type state_ff, state_in;

   logic [7:0]  cutoff_ff;
   logic [6:0]  percent_ff;
   logic        conflict_ff, conflict_in;

   logic [7:0]  thr_ff, thr_in;
   logic        light_ff, light_in;
   logic        agree_ff, agree_in;
   logic        enabled_ff;
   logic        active_ff, active_in;
   logic [10:0] ls_ff, ls_in;
   logic [10:0] rs_ff, rs_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [14:0] torque_ff;
   logic [15:0] left_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [pta_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic [7:0]  ta, tb, brake, steer;
   logic        enabled;
   logic [7:0]  hi, lo;
   logic [7:0]  bias;
   logic [14:0] bias125;
   logic [9:0]  q;
   logic [10:0] scale_plus, scale_minus;
   logic [6:0]  pct_sat;
   logic        accept, out_free;
   logic [MW-1:0] mul_a, mul_b;
   logic        load_torque, load_left, load_out;
   logic [15:0] prod_sat, right_val, left_val;

   function automatic logic [10:0] clamp_scale(input logic [10:0] s);
      logic [10:0] r;
      r = s;
      if (s < pta_pkg::SCALE_MIN) r = pta_pkg::SCALE_MIN;
      else if (s > pta_pkg::SCALE_MAX) r = pta_pkg::SCALE_MAX;
      return r;
   endfunction

   assign req_tready = (state_ff == pta_pkg::ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // frame decode
   assign ta      = req_tdata[7:0];
   assign tb      = req_tdata[15:8];
   assign brake   = req_tdata[23:16];
   assign steer   = req_tdata[31:24];
   assign enabled = req_tdata[32];

   assign hi       = (ta > tb) ? ta : tb;
   assign lo       = (ta > tb) ? tb : ta;
   assign agree_in = (8'(hi - lo) < pta_pkg::AGREE_LIMIT);
   assign thr_in   = agree_in ? lo : 8'd0;
   assign light_in = (brake >= cutoff_ff);

   always_comb begin
      conflict_in = conflict_ff;
      if (enabled && agree_in) begin
         if (conflict_ff) begin
            if (thr_in < pta_pkg::RELEASE_LIMIT) conflict_in = 1'b0;
         end else if (thr_in >= pta_pkg::PUSH_LIMIT &&
                      brake >= pta_pkg::BRAKE_CONFLICT_LIMIT) begin
            conflict_in = 1'b1;
         end
      end
   end

   assign active_in = enabled & agree_in & ~conflict_in;

   // steering bias, d*1000/128 = d*125/16
   assign bias        = steer[7] ? {1'b0, steer[6:0]} : 8'(pta_pkg::STEER_CENTER - steer);
   assign bias125     = ({bias, 7'd0}) - ({7'd0, bias} << 2) + {7'd0, bias};
   assign q           = bias125[13:4];
   assign scale_plus  = pta_pkg::SCALE_UNIT + {1'b0, q};
   assign scale_minus = pta_pkg::SCALE_UNIT - {1'b0, q};
   assign rs_in       = clamp_scale(steer[7] ? scale_plus : scale_minus);
   assign ls_in       = clamp_scale(steer[7] ? scale_minus : scale_plus);

   assign pct_sat = (percent_ff > pta_pkg::PERCENT_FULL) ? pta_pkg::PERCENT_FULL : percent_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pta_pkg::ST_IDLE:  if (accept) state_in = pta_pkg::ST_MUL_P;
         pta_pkg::ST_MUL_P: state_in = pta_pkg::ST_MUL_T;
         pta_pkg::ST_MUL_T: state_in = pta_pkg::ST_MUL_L;
         pta_pkg::ST_MUL_L: state_in = pta_pkg::ST_DIV_L;
         pta_pkg::ST_DIV_L: state_in = pta_pkg::ST_MUL_R;
         pta_pkg::ST_MUL_R: state_in = pta_pkg::ST_DIV_R;
         pta_pkg::ST_DIV_R: state_in = pta_pkg::ST_DONE;
         pta_pkg::ST_DONE:  if (out_free) state_in = pta_pkg::ST_IDLE;
         default:           state_in = pta_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      mul_a       = '0;
      mul_b       = '0;
      load_torque = 1'b0;
      load_left   = 1'b0;
      load_out    = 1'b0;
      case (state_ff)
         pta_pkg::ST_MUL_P: begin
            mul_a = MW'(thr_ff);
            mul_b = MW'(pct_sat);
         end
         pta_pkg::ST_MUL_T: begin
            mul_a = MW'(prod_ff[14:0]);
            mul_b = pta_pkg::RECIP_25;
         end
         pta_pkg::ST_MUL_L: begin
            mul_a       = MW'(prod_ff[33:19]);
            mul_b       = MW'(ls_ff);
            load_torque = 1'b1;
         end
         pta_pkg::ST_DIV_L: begin
            mul_a = MW'(prod_ff[25:3]);
            mul_b = pta_pkg::RECIP_125;
         end
         pta_pkg::ST_MUL_R: begin
            mul_a     = MW'(torque_ff);
            mul_b     = MW'(rs_ff);
            load_left = 1'b1;
         end
         pta_pkg::ST_DIV_R: begin
            mul_a = MW'(prod_ff[25:3]);
            mul_b = pta_pkg::RECIP_125;
         end
         pta_pkg::ST_DONE: begin
            load_out = out_free;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign prod_in  = PW'(mul_a) * PW'(mul_b);
   assign prod_sat = (|prod_ff[47:46]) ? pta_pkg::WORD_MAX : prod_ff[45:30];

   assign left_val  = active_ff ? left_ff : 16'd0;
   assign right_val = active_ff ? prod_sat : 16'd0;

   assign rsp_data_in = {4'd0,
                         16'(16'd0 - right_val),
                         left_val,
                         enabled_ff,
                         conflict_ff,
                         agree_ff,
                         thr_ff,
                         light_ff};

   assign rsp_valid_in = load_out ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pta_pkg::ST_IDLE;
         cutoff_ff    <= pta_pkg::CUTOFF_RESET;
         percent_ff   <= pta_pkg::PERCENT_RESET;
         conflict_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) conflict_ff <= conflict_in;
         if (csr_we) begin
            case (csr_index)
               pta_pkg::CSR_BRAKE_CUTOFF:  cutoff_ff  <= csr_wdata;
               pta_pkg::CSR_SCALE_PERCENT: percent_ff <= csr_wdata[6:0];
               default:                    cutoff_ff  <= cutoff_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      // right product is held while the result waits
      if (state_ff != pta_pkg::ST_DONE) prod_ff <= prod_in;
      if (accept) begin
         thr_ff     <= thr_in;
         light_ff   <= light_in;
         agree_ff   <= agree_in;
         enabled_ff <= enabled;
         active_ff  <= active_in;
         ls_ff      <= ls_in;
         rs_ff      <= rs_in;
      end
      if (load_torque) torque_ff <= prod_ff[33:19];
      if (load_left)   left_ff   <= prod_sat;
      if (load_out)    rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pedal torque arbiter. A queue of planned pedal
// frames and register writes feeds a request driver; a monitor predicts the
// torque command for every accepted frame and compares each result beat field
// by field. Both sides idle at random, with calm stretches in between.
// ----------------------------------------------------------------------------
module tb;

   typedef struct packed {
      logic       drive_enabled;
      logic [7:0] steering_pos;
      logic [7:0] brake_level;
      logic [7:0] throttle_b;
      logic [7:0] throttle_a;
   } frame_type;

   typedef struct packed {
      logic [15:0] right_torque_word;
      logic [15:0] left_torque;
      logic        torque_sent;
      logic        conflict_flag;
      logic        sensors_agree;
      logic [7:0]  throttle_used;
      logic        brake_light;
   } command_type;

   typedef enum logic [1:0] {
      STEP_FRAME,
      STEP_WRITE,
      STEP_DRAIN
   } step_kind_type;

   typedef struct {
      step_kind_type kind;
      frame_type     frame;
      int unsigned   gap;
      logic          index;
      logic [7:0]    wdata;
   } plan_step_type;

   localparam int unsigned SETTLE = 12;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [pta_pkg::REQ_W-1:0] req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [pta_pkg::RSP_W-1:0] rsp_tdata;
   logic              csr_we = 1'b0;
   logic              csr_index = 1'b0;
   logic [7:0]        csr_wdata = '0;

   plan_step_type drive_plan[$];
   command_type   pending_commands[$];
   logic [7:0]   light_cutoff = pta_pkg::CUTOFF_RESET;
   logic [6:0]   torque_percent = pta_pkg::PERCENT_RESET;
   bit           conflict_latch = 1'b0;
   int unsigned  mismatches = 0;
   int unsigned  quiet = 0;
   int unsigned  send_calm = 0;
   int unsigned  recv_calm = 0;
   int unsigned  recv_wait = 0;
   int unsigned  gap_left = 0;
   bit           head_armed = 1'b0;
   bit           req_fire = 1'b0;
   bit           rsp_fire = 1'b0;

   pedal_torque_arbiter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned draw_pause(ref int unsigned calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 4);
   endfunction

   function automatic logic [15:0] wheel_torque(int unsigned torque, int unsigned scale);
      int unsigned s;
      int unsigned v;
      s = scale < pta_pkg::SCALE_MIN ? pta_pkg::SCALE_MIN :
          (scale > pta_pkg::SCALE_MAX ? pta_pkg::SCALE_MAX : scale);
      v = torque * s / pta_pkg::SCALE_UNIT;
      return v > pta_pkg::WORD_MAX ? pta_pkg::WORD_MAX : v[15:0];
   endfunction

   function automatic command_type command_for_frame(frame_type f);
      command_type c;
      logic [7:0]  hi;
      logic [7:0]  lo;
      logic [7:0]  thr;
      bit          agree;
      int unsigned pct;
      int unsigned torque;
      int unsigned q;
      int unsigned rs;
      int unsigned ls;
      logic [15:0] right;
      hi = f.throttle_a > f.throttle_b ? f.throttle_a : f.throttle_b;
      lo = f.throttle_a > f.throttle_b ? f.throttle_b : f.throttle_a;
      agree = (hi - lo) < pta_pkg::AGREE_LIMIT;
      thr = agree ? lo : 8'd0;
      c = '0;
      right = '0;
      c.brake_light = f.brake_level >= light_cutoff;
      c.throttle_used = thr;
      c.sensors_agree = agree;
      c.torque_sent = f.drive_enabled;
      if (f.drive_enabled && agree) begin
         if (conflict_latch) begin
            if (thr < pta_pkg::RELEASE_LIMIT) conflict_latch = 1'b0;
         end else if (thr >= pta_pkg::PUSH_LIMIT &&
                      f.brake_level >= pta_pkg::BRAKE_CONFLICT_LIMIT) begin
            conflict_latch = 1'b1;
         end
         if (!conflict_latch) begin
            pct = torque_percent > pta_pkg::PERCENT_FULL ? pta_pkg::PERCENT_FULL :
                  torque_percent;
            torque = ((int'(thr) << 7) * pct) / pta_pkg::PERCENT_FULL;
            if (f.steering_pos >= pta_pkg::STEER_CENTER) begin
               q = (f.steering_pos - pta_pkg::STEER_CENTER) * pta_pkg::SCALE_UNIT /
                   pta_pkg::STEER_CENTER;
               rs = pta_pkg::SCALE_UNIT + q;
               ls = pta_pkg::SCALE_UNIT - q;
            end else begin
               q = (pta_pkg::STEER_CENTER - f.steering_pos) * pta_pkg::SCALE_UNIT /
                   pta_pkg::STEER_CENTER;
               rs = pta_pkg::SCALE_UNIT - q;
               ls = pta_pkg::SCALE_UNIT + q;
            end
            c.left_torque = wheel_torque(torque, ls);
            right = wheel_torque(torque, rs);
         end
      end
      c.conflict_flag = conflict_latch;
      c.right_torque_word = 16'd0 - right;
      return c;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", name, want, got);
         mismatches++;
      end
   endtask

   task automatic add_frame(input int ta, input int tb_val, input int brake, input int steer,
                            input bit en);
      plan_step_type s;
      s.kind = STEP_FRAME;
      s.frame.throttle_a = ta[7:0];
      s.frame.throttle_b = tb_val[7:0];
      s.frame.brake_level = brake[7:0];
      s.frame.steering_pos = steer[7:0];
      s.frame.drive_enabled = en;
      s.gap = draw_pause(send_calm);
      s.index = 1'b0;
      s.wdata = '0;
      drive_plan.push_back(s);
   endtask

   task automatic add_write(input logic index, input logic [7:0] wdata);
      plan_step_type s;
      s.kind = STEP_WRITE;
      s.frame = '0;
      s.gap = 0;
      s.index = index;
      s.wdata = wdata;
      drive_plan.push_back(s);
   endtask

   task automatic add_drain();
      plan_step_type s;
      s.kind = STEP_DRAIN;
      s.frame = '0;
      s.gap = 0;
      s.index = 1'b0;
      s.wdata = '0;
      drive_plan.push_back(s);
   endtask

   // mostly plausible frames in throttle bands that walk the conflict latch
   task automatic add_random_frames(input int n);
      int ta;
      int d;
      int tb_val;
      int band;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 15) begin
            add_frame($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 1));
         end else begin
            band = $urandom_range(0, 3);
            case (band)
               0: ta = $urandom_range(0, 12);
               1: ta = $urandom_range(13, 63);
               2: ta = $urandom_range(64, 255);
               default: ta = $urandom_range(0, 255);
            endcase
            d = $urandom_range(0, 9) == 0 ? $urandom_range(25, 60) : $urandom_range(0, 24);
            if ((ta >= d && $urandom_range(0, 1)) || ta + d > 255) tb_val = ta - d;
            else tb_val = ta + d;
            if (tb_val < 0) tb_val = 0;
            if ($urandom_range(0, 1)) add_frame(tb_val, ta, $urandom_range(0, 255),
                                                $urandom_range(0, 255),
                                                $urandom_range(0, 9) != 0);
            else add_frame(ta, tb_val, $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 9) != 0);
         end
      end
   endtask

   always @(negedge clock) begin : drive_req
      logic send;
      logic we;
      send = req_tvalid && !req_fire;
      we = 1'b0;
      if (!reset && !send && drive_plan.size() > 0) begin
         if (!head_armed) begin
            gap_left = drive_plan[0].gap;
            head_armed = 1'b1;
         end
         if (gap_left > 0) begin
            gap_left--;
         end else begin
            case (drive_plan[0].kind)
               STEP_FRAME: begin
                  req_tdata <= {{(pta_pkg::REQ_W - 33){1'b0}}, drive_plan[0].frame};
                  send = 1'b1;
                  void'(drive_plan.pop_front());
                  head_armed = 1'b0;
               end
               STEP_WRITE: begin
                  if (quiet >= SETTLE) begin
                     we = 1'b1;
                     csr_index <= drive_plan[0].index;
                     csr_wdata <= drive_plan[0].wdata;
                     void'(drive_plan.pop_front());
                     head_armed = 1'b0;
                  end
               end
               default: begin
                  if (quiet >= SETTLE) begin
                     void'(drive_plan.pop_front());
                     head_armed = 1'b0;
                  end
               end
            endcase
         end
      end
      req_tvalid <= send;
      csr_we <= we;
   end

   always @(negedge clock) begin : drive_rsp
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_fire) recv_wait = draw_pause(recv_calm);
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watch
      command_type got;
      command_type want;
      req_fire = 1'b0;
      rsp_fire = 1'b0;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               pta_pkg::CSR_BRAKE_CUTOFF:  light_cutoff = csr_wdata;
               pta_pkg::CSR_SCALE_PERCENT: torque_percent = csr_wdata[6:0];
               default:                    light_cutoff = light_cutoff;
            endcase
         end
         if (req_tvalid && req_tready) begin
            req_fire = 1'b1;
            pending_commands.push_back(command_for_frame(frame_type'(req_tdata[32:0])));
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_fire = 1'b1;
            got = command_type'(rsp_tdata[43:0]);
            if (pending_commands.size() == 0) begin
               $error("result beat with no frame pending");
               mismatches++;
            end else begin
               want = pending_commands.pop_front();
               check_field("brake_light", want.brake_light, got.brake_light);
               check_field("throttle_used", want.throttle_used, got.throttle_used);
               check_field("sensors_agree", want.sensors_agree, got.sensors_agree);
               check_field("conflict_flag", want.conflict_flag, got.conflict_flag);
               check_field("torque_sent", want.torque_sent, got.torque_sent);
               check_field("left_torque", want.left_torque, got.left_torque);
               check_field("right_torque_word", want.right_torque_word,
                           got.right_torque_word);
            end
         end
      end
      if (!reset && pending_commands.size() == 0 && !req_tvalid && !rsp_tvalid) quiet++;
      else quiet = 0;
   end

   initial begin
      // default registers: thresholds, latch set, hold and release
      add_frame(0, 0, 0, 0, 1);
      add_frame(255, 255, 255, 255, 0);
      add_frame(100, 124, 0, 128, 1);
      add_frame(124, 100, 0, 0, 1);
      add_frame(100, 125, 0, 255, 1);
      add_frame(125, 100, 255, 255, 1);
      add_frame(63, 63, 255, 31, 1);
      add_frame(64, 64, 49, 32, 1);
      add_frame(64, 64, 50, 224, 1);
      add_frame(200, 200, 0, 225, 1);
      add_frame(13, 13, 0, 127, 1);
      add_frame(200, 230, 0, 1, 1);
      add_frame(12, 12, 0, 1, 1);
      add_frame(255, 255, 0, 128, 1);
      add_frame(255, 255, 255, 129, 0);
      add_frame(255, 250, 255, 127, 1);
      add_frame(0, 30, 0, 0, 1);
      add_frame(5, 0, 0, 0, 0);
      add_frame(0, 0, 0, 0, 1);
      add_frame(255, 255, 49, 0, 1);
      add_frame(255, 255, 49, 255, 1);
      add_frame(24, 0, 50, 96, 1);

      add_write(pta_pkg::CSR_BRAKE_CUTOFF, 8'd0);
      add_write(pta_pkg::CSR_SCALE_PERCENT, 8'd0);
      add_random_frames(60);

      add_write(pta_pkg::CSR_BRAKE_CUTOFF, 8'd255);
      add_write(pta_pkg::CSR_SCALE_PERCENT, 8'hFF);
      add_random_frames(60);

      add_write(pta_pkg::CSR_BRAKE_CUTOFF, 8'd1);
      add_write(pta_pkg::CSR_SCALE_PERCENT, 8'd1);
      add_random_frames(30);
      add_drain();
      add_random_frames(30);

      add_write(pta_pkg::CSR_SCALE_PERCENT, 8'd101);
      add_write(pta_pkg::CSR_BRAKE_CUTOFF, 8'd254);
      add_random_frames(60);

      for (int p = 0; p < 4; p++) begin
         add_write(pta_pkg::CSR_BRAKE_CUTOFF, 8'($urandom_range(0, 255)));
         add_write(pta_pkg::CSR_SCALE_PERCENT, 8'($urandom_range(0, 255)));
         add_random_frames(65);
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (drive_plan.size() != 0 || req_tvalid || pending_commands.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

### sim.f
rtl/core/pta_pkg.sv
rtl/core/pedal_torque_arbiter.sv
dv/tb.sv
